// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the checker in pwmtsp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ----- hw/rtl/pwmtsp_pkg.sv -----
`timescale 1ns / 1ps

package pwmtsp_pkg;

  // Field widths
  localparam int KIND_W   = 2;
  localparam int INDEX_W  = 5;
  localparam int PERIOD_W = 16;
  localparam int TICKS_W  = 16;
  localparam int LEN_W    = 4;
  localparam int VOL_W    = 3;
  localparam int ENTRY_W  = PERIOD_W + TICKS_W;

  localparam logic [VOL_W-1:0] VOL_RESET = 3'd5;

  // Input item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_START = 2'd2
  } kind_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_WRITE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_TICK,
    ST_ADVANCE,
    ST_LOAD,
    ST_MUL
  } state_t;

  // Q0.16 duty factors, rounded up; codes above 5 act as 5
  function automatic logic [PERIOD_W-1:0] vol_factor(input logic [VOL_W-1:0] sel);
    logic [PERIOD_W-1:0] f;
    unique case (sel)
      3'd0:    f = 16'd0;
      3'd1:    f = 16'd3277;
      3'd2:    f = 16'd4588;
      3'd3:    f = 16'd6554;
      3'd4:    f = 16'd13108;
      default: f = 16'd32768;
    endcase
    return f;
  endfunction

endpackage

// ----- hw/rtl/pwm_tone_sequence_player.sv -----
`timescale 1ns / 1ps
// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------------------------
// item in  | start & !busy         | kind, entry_index, tone_period, tone_ticks
// result   | done (1-cycle strobe) | tone_on, pwm_period, pwm_compare,
//          |                       | sequence_busy
// config   | cfg_wr_en             | cfg_wr_data (volume select)
//
// States after acceptance: write REDUCE, WRITE; tick REDUCE, TICK, ADVANCE,
// then LOAD (table read) and MUL (the multiplier) when a new tone is loaded;
// start REDUCE, SCAN_RD, then one SCAN_CHK per table entry checked, up to
// MAX_SEQ_LEN. One more REDUCE per subtraction when entry_index >= TABLE_DEPTH.
// Synchronous active-high reset clears control state; the tone table is not
// cleared. Results cannot be stalled; the next beat is taken in the done cycle.

module pwm_tone_sequence_player #(
  parameter int TABLE_DEPTH = 32,
  parameter int MAX_SEQ_LEN = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [pwmtsp_pkg::KIND_W-1:0]   kind,
  input  logic [pwmtsp_pkg::INDEX_W-1:0]  entry_index,
  input  logic [pwmtsp_pkg::PERIOD_W-1:0] tone_period,
  input  logic [pwmtsp_pkg::TICKS_W-1:0]  tone_ticks,
  input  logic                            cfg_wr_en,
  input  logic [pwmtsp_pkg::VOL_W-1:0]    cfg_wr_data,
  output logic                            done,
  output logic                            tone_on,
  output logic [pwmtsp_pkg::PERIOD_W-1:0] pwm_period,
  output logic [pwmtsp_pkg::PERIOD_W-1:0] pwm_compare,
  output logic                            sequence_busy
);
  import pwmtsp_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int RED_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
  localparam int CMP_W = RED_W + 1;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [LEN_W-1:0] SCAN_LAST = LEN_W'(MAX_SEQ_LEN - 1);
  localparam logic [LEN_W-1:0] SCAN_MAX = LEN_W'(MAX_SEQ_LEN);

  state_t state, state_next;

  // Captured item
  logic [KIND_W-1:0]   kind_q;
  logic [PERIOD_W-1:0] period_q;
  logic [TICKS_W-1:0]  ticks_q;
  logic [RED_W-1:0]    red_idx;

  // Sequence and tone state
  logic [VOL_W-1:0]    volume_select;
  logic                seq_active;
  logic [IDX_W-1:0]    play_ptr;
  logic [LEN_W-1:0]    seq_length;
  logic [LEN_W-1:0]    seq_position;
  logic                tone_running;
  logic [TICKS_W-1:0]  ticks_left;
  logic [PERIOD_W-1:0] period_reg;
  logic [PERIOD_W-1:0] compare_reg;

  // Scan
  logic [IDX_W-1:0]    scan_ptr;
  logic [LEN_W-1:0]    scan_cnt;

  // Tone table
  logic [ENTRY_W-1:0]  tone_mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0]  rd_data;
  logic [IDX_W-1:0]    rd_addr;
  logic                mem_we;

  logic                finish;
  logic                reduce_ok;
  logic                scan_zero;
  logic                scan_stop;
  logic                play_next;
  logic [IDX_W-1:0]    scan_ptr_inc;
  logic [IDX_W-1:0]    play_ptr_inc;
  logic [IDX_W-1:0]    base_ptr_inc;
  logic [PERIOD_W-1:0] duty_compare;

  // Status decodes
  always_comb begin
    reduce_ok    = !({1'b0, red_idx} >= DEPTH_C);
    scan_zero    = (rd_data[ENTRY_W-1:TICKS_W] == '0);
    scan_stop    = scan_zero || (scan_cnt == SCAN_LAST);
    play_next    = seq_active && !tone_running && (seq_position < seq_length);
    scan_ptr_inc = (scan_ptr == LAST_IDX) ? '0 : scan_ptr + 1'b1;
    play_ptr_inc = (play_ptr == LAST_IDX) ? '0 : play_ptr + 1'b1;
    base_ptr_inc = (red_idx[IDX_W-1:0] == LAST_IDX) ? '0 : red_idx[IDX_W-1:0] + 1'b1;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (start) state_next = ST_REDUCE;
      ST_REDUCE: begin
        if (reduce_ok) begin
          unique case (kind_q)
            KIND_TICK:  state_next = ST_TICK;
            KIND_WRITE: state_next = ST_WRITE;
            KIND_START: state_next = ST_SCAN_RD;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_WRITE:    state_next = ST_IDLE;
      ST_SCAN_RD:  state_next = ST_SCAN_CHK;
      ST_SCAN_CHK: if (scan_stop) state_next = ST_IDLE;
      ST_TICK:     state_next = ST_ADVANCE;
      ST_ADVANCE:  state_next = play_next ? ST_LOAD : ST_IDLE;
      ST_LOAD:     state_next = ST_MUL;
      ST_MUL:      state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    finish  = 1'b0;
    mem_we  = 1'b0;
    rd_addr = play_ptr;
    unique case (state)
      ST_REDUCE:   finish = reduce_ok && (kind_q != KIND_TICK) &&
                            (kind_q != KIND_WRITE) && (kind_q != KIND_START);
      ST_WRITE: begin
        mem_we = 1'b1;
        finish = 1'b1;
      end
      ST_SCAN_RD:  rd_addr = red_idx[IDX_W-1:0];
      ST_SCAN_CHK: begin
        rd_addr = scan_ptr;
        finish  = scan_stop;
      end
      ST_ADVANCE:  finish = !play_next;
      ST_MUL:      finish = 1'b1;
      default:     finish = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

  // Volume register
  always_ff @(posedge clk) begin
    if (rst) begin
      volume_select <= VOL_RESET;
    end else if (cfg_wr_en) begin
      volume_select <= cfg_wr_data;
    end
  end

  // Item capture and index reduction by repeated subtraction
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      kind_q   <= kind;
      period_q <= tone_period;
      ticks_q  <= tone_ticks;
      red_idx  <= RED_W'(entry_index);
    end else if (state == ST_REDUCE && !reduce_ok) begin
      red_idx <= RED_W'({1'b0, red_idx} - DEPTH_C);
    end
  end

  // Tone table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tone_mem[red_idx[IDX_W-1:0]] <= {period_q, ticks_q};
    end
    rd_data <= tone_mem[rd_addr];
  end

  // Terminator scan, one entry per cycle
  always_ff @(posedge clk) begin
    if (state == ST_SCAN_RD) begin
      scan_ptr <= base_ptr_inc;
      scan_cnt <= '0;
    end else if (state == ST_SCAN_CHK) begin
      scan_ptr <= scan_ptr_inc;
      scan_cnt <= scan_cnt + 1'b1;
    end
  end

  // Sequence and tone state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_active   <= 1'b0;
      play_ptr     <= '0;
      seq_length   <= '0;
      seq_position <= '0;
      tone_running <= 1'b0;
      ticks_left   <= '0;
      period_reg   <= '0;
      compare_reg  <= '0;
    end else begin
      unique case (state)
        ST_SCAN_CHK: begin
          if (scan_stop) begin
            play_ptr     <= red_idx[IDX_W-1:0];
            seq_length   <= scan_zero ? scan_cnt : SCAN_MAX;
            seq_position <= '0;
            seq_active   <= 1'b1;
          end
        end
        ST_TICK: begin
          if (tone_running && ticks_left != '0) begin
            ticks_left <= ticks_left - 1'b1;
            if (ticks_left == TICKS_W'(1)) tone_running <= 1'b0;
          end
        end
        ST_ADVANCE: begin
          if (seq_active && !tone_running && !(seq_position < seq_length)) begin
            seq_active <= 1'b0;
          end
        end
        ST_LOAD: begin
          period_reg   <= rd_data[ENTRY_W-1:TICKS_W];
          ticks_left   <= rd_data[TICKS_W-1:0];
          tone_running <= 1'b1;
          play_ptr     <= play_ptr_inc;
          seq_position <= seq_position + 1'b1;
        end
        ST_MUL:  compare_reg <= duty_compare;
        default: ;
      endcase
    end
  end

  // Multiplier for the compare value
  pwmtsp_duty u_duty (
    .clk     (clk),
    .period  (rd_data[ENTRY_W-1:TICKS_W]),
    .vol_sel (volume_select),
    .compare (duty_compare)
  );

  assign busy          = (state != ST_IDLE);
  assign tone_on       = tone_running;
  assign pwm_period    = period_reg;
  assign pwm_compare   = compare_reg;
  assign sequence_busy = seq_active;

endmodule

// ----- hw/rtl/pwmtsp_duty.sv -----
`timescale 1ns / 1ps

module pwmtsp_duty (
  input  logic                            clk,
  input  logic [pwmtsp_pkg::PERIOD_W-1:0] period,
  input  logic [pwmtsp_pkg::VOL_W-1:0]    vol_sel,
  output logic [pwmtsp_pkg::PERIOD_W-1:0] compare
);
  import pwmtsp_pkg::*;

  logic [2*PERIOD_W-1:0] prod_full;

  // period times Q0.16 fraction, keep the integer part
  always_comb begin
    prod_full = {{PERIOD_W{1'b0}}, period} * {{PERIOD_W{1'b0}}, vol_factor(vol_sel)};
  end

  always_ff @(posedge clk) begin
    compare <= prod_full[2*PERIOD_W-1:PERIOD_W];
  end

endmodule

// ----- hw/rtl/pwmtsp_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pwmtsp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            done,
  input logic                            tone_on,
  input logic [pwmtsp_pkg::PERIOD_W-1:0] pwm_period,
  input logic [pwmtsp_pkg::PERIOD_W-1:0] pwm_compare,
  input logic                            sequence_busy
);
  import pwmtsp_pkg::*;

  // Accepted beat always puts the block to work
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // Result beat only appears once the sequencer is back to idle
  `ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  // Result strobe lasts a single cycle
  `ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  // State shown on the result ports holds while no beat is in work
  `ASSERT_NEXT(a_idle_hold, clk, rst, !busy && !start,
    $stable(pwm_period) && $stable(pwm_compare) && $stable(tone_on) &&
    $stable(sequence_busy))

endmodule

bind pwm_tone_sequence_player pwmtsp_checker u_pwmtsp_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .tone_on       (tone_on),
  .pwm_period    (pwm_period),
  .pwm_compare   (pwm_compare),
  .sequence_busy (sequence_busy)
);

// ----- verif/tone_player_checker.sv -----
`timescale 1ns / 1ps

module tone_player_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic [pwmtsp_pkg::KIND_W-1:0]   kind,
  input  logic [pwmtsp_pkg::INDEX_W-1:0]  entry_index,
  input  logic [pwmtsp_pkg::PERIOD_W-1:0] tone_period,
  input  logic [pwmtsp_pkg::TICKS_W-1:0]  tone_ticks,
  input  logic                            cfg_wr_en,
  input  logic [pwmtsp_pkg::VOL_W-1:0]    cfg_wr_data,
  input  logic                            done,
  input  logic                            tone_on,
  input  logic [pwmtsp_pkg::PERIOD_W-1:0] pwm_period,
  input  logic [pwmtsp_pkg::PERIOD_W-1:0] pwm_compare,
  input  logic                            sequence_busy,
  output int                              pending_beats,
  output int                              fail_count
);
  import pwmtsp_pkg::*;

  localparam int DEPTH    = 32;
  localparam int SCAN_MAX = 10;
  localparam int MAX_LINES = 40;

  typedef struct packed {
    logic                tone_on;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] compare;
    logic                seq_busy;
  } tone_status_t;

  // predicted player state
  logic [PERIOD_W-1:0] tbl_period [DEPTH];
  logic [TICKS_W-1:0]  tbl_ticks  [DEPTH];
  logic [VOL_W-1:0]    volume;
  logic                seq_on;
  logic                playing;
  logic [INDEX_W-1:0]  seq_first;
  logic [LEN_W-1:0]    seq_len;
  logic [LEN_W-1:0]    seq_pos;
  logic [TICKS_W-1:0]  ticks_remaining;
  logic [PERIOD_W-1:0] cur_period;
  logic [PERIOD_W-1:0] cur_compare;

  tone_status_t status_q [$];
  tone_status_t want;
  tone_status_t next_status;
  int           mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_LINES) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Q0.16 duty, rounded up; codes 5 and above play at 50 %
  function automatic logic [15:0] duty_q16(input logic [VOL_W-1:0] sel);
    logic [15:0] q;
    case (sel)
      3'd0:    q = 16'd0;
      3'd1:    q = 16'd3277;
      3'd2:    q = 16'd4588;
      3'd3:    q = 16'd6554;
      3'd4:    q = 16'd13108;
      default: q = 16'd32768;
    endcase
    return q;
  endfunction

  task automatic clear_player();
    for (int i = 0; i < DEPTH; i++) begin
      tbl_period[i] = '0;
      tbl_ticks[i]  = '0;
    end
    volume          = VOL_RESET;
    seq_on          = 1'b0;
    playing         = 1'b0;
    seq_first       = '0;
    seq_len         = '0;
    seq_pos         = '0;
    ticks_remaining = '0;
    cur_period      = '0;
    cur_compare     = '0;
  endtask

  task automatic load_tone(input logic [INDEX_W-1:0] slot);
    logic [31:0] prod;
    prod            = {16'd0, tbl_period[slot]} * {16'd0, duty_q16(volume)};
    cur_period      = tbl_period[slot];
    cur_compare     = prod[31:16];
    ticks_remaining = tbl_ticks[slot];
    playing         = 1'b1;
  endtask

  // one tick: count down, then advance or close the sequence
  task automatic tick_player();
    logic [INDEX_W-1:0] slot;
    if (playing && ticks_remaining != 0) begin
      ticks_remaining = ticks_remaining - 16'd1;
      if (ticks_remaining == 0) playing = 1'b0;
    end
    if (seq_on && !playing) begin
      if (seq_pos < seq_len) begin
        slot = seq_first + {1'b0, seq_pos};
        load_tone(slot);
        seq_pos = seq_pos + 4'd1;
      end else begin
        seq_on = 1'b0;
      end
    end
  endtask

  // length is the count of entries before the first zero period, capped at SCAN_MAX
  task automatic start_sequence(input logic [INDEX_W-1:0] first);
    int                 len;
    bit                 found;
    logic [INDEX_W-1:0] slot;
    len   = SCAN_MAX;
    found = 1'b0;
    for (int i = 0; i < SCAN_MAX; i++) begin
      slot = first + i[INDEX_W-1:0];
      if (!found && tbl_period[slot] == 0) begin
        len   = i;
        found = 1'b1;
      end
    end
    seq_first = first;
    seq_len   = len[LEN_W-1:0];
    seq_pos   = '0;
    seq_on    = 1'b1;
  endtask

  task automatic apply_beat(input logic [KIND_W-1:0] k, input logic [INDEX_W-1:0] idx,
                            input logic [PERIOD_W-1:0] per, input logic [TICKS_W-1:0] tks,
                            output tone_status_t st);
    case (k)
      KIND_TICK: tick_player();
      KIND_WRITE: begin
        tbl_period[idx] = per;
        tbl_ticks[idx]  = tks;
      end
      KIND_START: start_sequence(idx);
      default: ;
    endcase
    st.tone_on  = playing;
    st.period   = cur_period;
    st.compare  = cur_compare;
    st.seq_busy = seq_on;
  endtask

  // result beats are checked before the beat accepted at the same edge is predicted
  always @(posedge clk) begin
    if (rst) begin
      clear_player();
      status_q.delete();
      pending_beats <= 0;
    end else begin
      if (cfg_wr_en) volume = cfg_wr_data;
      if (done) begin
        if (status_q.size() == 0) begin
          report_mismatch("result beat with nothing pending");
        end else begin
          want = status_q.pop_front();
          if (tone_on !== want.tone_on)
            report_mismatch($sformatf("tone_on got %0b expected %0b", tone_on, want.tone_on));
          if (pwm_period !== want.period)
            report_mismatch($sformatf("pwm_period got %0d expected %0d",
                                      pwm_period, want.period));
          if (pwm_compare !== want.compare)
            report_mismatch($sformatf("pwm_compare got %0d expected %0d",
                                      pwm_compare, want.compare));
          if (sequence_busy !== want.seq_busy)
            report_mismatch($sformatf("sequence_busy got %0b expected %0b",
                                      sequence_busy, want.seq_busy));
        end
      end
      if (start && !busy) begin
        apply_beat(kind, entry_index, tone_period, tone_ticks, next_status);
        status_q.push_back(next_status);
      end
      pending_beats <= status_q.size();
    end
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import pwmtsp_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int DEPTH          = 32;
  localparam int SCAN_MAX       = 10;
  localparam int PHASE_ITEMS    = 50;
  localparam int MAX_PLAY_TICKS = 8;
  localparam int TAIL_CYCLES    = 20;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [KIND_W-1:0]   kind = KIND_TICK;
  logic [INDEX_W-1:0]  entry_index = '0;
  logic [PERIOD_W-1:0] tone_period = '0;
  logic [TICKS_W-1:0]  tone_ticks = '0;
  logic                cfg_wr_en = 1'b0;
  logic [VOL_W-1:0]    cfg_wr_data = VOL_RESET;
  logic                busy;
  logic                done;
  logic                tone_on;
  logic [PERIOD_W-1:0] pwm_period;
  logic [PERIOD_W-1:0] pwm_compare;
  logic                sequence_busy;
  int                  pending_beats;
  int                  fail_count;

  // stimulus-side view of the table, so starts never read a blank entry
  bit                  written [DEPTH];
  logic [PERIOD_W-1:0] shadow_period [DEPTH];
  logic [TICKS_W-1:0]  shadow_ticks [DEPTH];
  logic [INDEX_W-1:0]  window_first = '0;
  int                  window_len = 0;
  int                  burst_left = 0;
  int                  sent_items = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pwm_tone_sequence_player dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .entry_index  (entry_index),
    .tone_period  (tone_period),
    .tone_ticks   (tone_ticks),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .done         (done),
    .tone_on      (tone_on),
    .pwm_period   (pwm_period),
    .pwm_compare  (pwm_compare),
    .sequence_busy(sequence_busy)
  );

  tone_player_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .entry_index  (entry_index),
    .tone_period  (tone_period),
    .tone_ticks   (tone_ticks),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .done         (done),
    .tone_on      (tone_on),
    .pwm_period   (pwm_period),
    .pwm_compare  (pwm_compare),
    .sequence_busy(sequence_busy),
    .pending_beats(pending_beats),
    .fail_count   (fail_count)
  );

  // drive one beat and hold it until accepted; bursts with random gaps between
  task automatic send_beat(input logic [KIND_W-1:0] k, input logic [INDEX_W-1:0] idx,
                           input logic [PERIOD_W-1:0] per, input logic [TICKS_W-1:0] tks);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start       <= 1'b1;
    kind        <= k;
    entry_index <= idx;
    tone_period <= per;
    tone_ticks  <= tks;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_items++;
  endtask

  // ignored fields are random
  task automatic tick_beat();
    send_beat(KIND_TICK, 5'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // hold off until every predicted result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
  endtask

  task automatic write_volume(input logic [VOL_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // entries the active sequence may still play keep a short duration unless raw
  task automatic put_entry(input logic [INDEX_W-1:0] idx, input logic [PERIOD_W-1:0] per,
                           input logic [TICKS_W-1:0] tks, input bit raw);
    logic [TICKS_W-1:0] t;
    logic [INDEX_W-1:0] off;
    t   = tks;
    off = idx - window_first;
    if (!raw && int'(off) < window_len && (t == 0 || t > MAX_PLAY_TICKS))
      t = 16'($urandom_range(1, 4));
    written[idx]       = 1'b1;
    shadow_period[idx] = per;
    shadow_ticks[idx]  = t;
    send_beat(KIND_WRITE, idx, per, t);
  endtask

  // -1 when the scan would touch a blank entry or play a long or endless tone
  function automatic int scan_len(input logic [INDEX_W-1:0] first, input bit zero_ok);
    logic [INDEX_W-1:0] e;
    for (int i = 0; i < SCAN_MAX; i++) begin
      e = first + 5'(i);
      if (!written[e]) return -1;
      if (shadow_period[e] == 0) return i;
      if (shadow_ticks[e] > MAX_PLAY_TICKS || (shadow_ticks[e] == 0 && !zero_ok)) return -1;
    end
    return SCAN_MAX;
  endfunction

  task automatic try_start(input logic [INDEX_W-1:0] first, input bit zero_ok);
    int len;
    len = scan_len(first, zero_ok);
    if (len < 0) begin
      tick_beat();
    end else begin
      window_first = first;
      window_len   = len;
      send_beat(KIND_START, first, 16'($urandom), 16'($urandom));
    end
  endtask

  function automatic logic [PERIOD_W-1:0] rand_period();
    case ($urandom_range(0, 7))
      0:       return 16'hFFFF;
      1:       return 16'd1;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // built sequences with random content in 45 of 100 picks, the rest noise
  task automatic random_phase(input int n);
    int                 first_item;
    int                 pick;
    int                 count;
    logic [INDEX_W-1:0] base;
    first_item = sent_items;
    while (sent_items - first_item < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        base  = 5'($urandom);
        count = ($urandom_range(0, 9) == 0) ? SCAN_MAX : $urandom_range(1, 4);
        for (int i = 0; i < count; i++)
          put_entry(base + 5'(i), rand_period(), 16'($urandom_range(1, 4)), 1'b0);
        if (count < SCAN_MAX) put_entry(base + 5'(count), 16'd0, 16'($urandom), 1'b0);
        try_start(base, 1'b0);
        repeat ($urandom_range(2, 12)) tick_beat();
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 6)) tick_beat();
      end else if (pick < 80) begin
        put_entry(5'($urandom), ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom),
                  16'($urandom), 1'b0);
      end else if (pick < 90) begin
        try_start(5'($urandom), 1'b0);
      end else begin
        send_beat(KIND_UNUSED, 5'($urandom), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  // run limit
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [VOL_W-1:0] vols [8];
    vols = '{3'd0, 3'd7, 3'd1, 3'd2, 3'd6, 3'd3, 3'd4, 3'd5};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset state, idle tick, wrapped sequence at full period
    send_beat(KIND_UNUSED, 5'd31, 16'hFFFF, 16'hFFFF);
    tick_beat();
    put_entry(5'd30, 16'hFFFF, 16'd1, 1'b0);
    put_entry(5'd31, 16'd1, 16'd2, 1'b0);
    put_entry(5'd0, 16'h8000, 16'd1, 1'b0);
    put_entry(5'd1, 16'd0, 16'hFFFF, 1'b0);
    try_start(5'd30, 1'b0);
    repeat (7) tick_beat();
    // restart while the tone still runs
    put_entry(5'd5, 16'd1000, 16'd3, 1'b0);
    put_entry(5'd6, 16'd0, 16'd0, 1'b0);
    try_start(5'd5, 1'b0);
    tick_beat();
    try_start(5'd5, 1'b0);
    repeat (5) tick_beat();

    // random phases, each under its own volume
    foreach (vols[i]) begin
      write_volume(vols[i]);
      random_phase(PHASE_ITEMS);
    end

    // last: a tone with no duration holds the sequence for good
    write_volume(3'd3);
    put_entry(5'd10, 16'hABCD, 16'd0, 1'b1);
    put_entry(5'd11, 16'd0, 16'd9, 1'b1);
    try_start(5'd10, 1'b1);
    repeat (3) tick_beat();
    try_start(5'd10, 1'b1);
    repeat (2) tick_beat();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
